### rtl/slfa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slfa_pkg
// Shared constants, codes and types for the slot free-list allocator.
// ----------------------------------------------------------------------------
package slfa_pkg;

	localparam int SLOT_COUNT = 1024;
	localparam int SLOT_W     = $clog2(SLOT_COUNT);
	localparam int FILL_W     = SLOT_W + 1;

	localparam int REG_W      = 11;
	localparam int RUN_W      = 11;
	localparam int SLOT_IN_W  = 16;
	localparam int ACT_W      = 2;
	localparam int SLOT_OUT_W = 10;
	localparam int STATUS_W   = 3;

	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 16;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_RUN     = 2'd1;
	localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_UNUSED    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_RUN       = 3'd4;

	localparam logic REG_START = 1'b0;
	localparam logic REG_END   = 1'b1;

	localparam logic [REG_W-1:0] REGION_END_RST = REG_W'(1024);

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		logic              data;
	} bm_wr_t;

	typedef struct packed {
		logic              pop;
		logic              push;
		logic [SLOT_W-1:0] push_data;
	} fifo_ctl_t;

	function automatic logic [SLOT_W-1:0] ptr_inc(input logic [SLOT_W-1:0] p);
		logic [SLOT_W-1:0] r;
		if (p == SLOT_W'(SLOT_COUNT - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### rtl/slfa_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slfa_regs
// APB register file holding the region bounds.
// ----------------------------------------------------------------------------
module slfa_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [slfa_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [slfa_pkg::APB_DATA_W-1:0]  pwdata,
	output logic      [slfa_pkg::APB_DATA_W-1:0]  prdata,
	output logic                                  pready,
	output logic      [slfa_pkg::REG_W-1:0]       region_start,
	output logic      [slfa_pkg::REG_W-1:0]       region_end,
	output logic                                  start_load
);
	import slfa_pkg::*;

	logic             wr_en;
	logic             reg_sel;
	logic [REG_W-1:0] start_q;
	logic [REG_W-1:0] end_q;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			end_q   <= REGION_END_RST;
		end else if (wr_en) begin
			if (reg_sel == REG_START) begin
				start_q <= pwdata[REG_W-1:0];
			end else begin
				end_q <= pwdata[REG_W-1:0];
			end
		end
	end

	always_comb begin
		if (reg_sel == REG_START) begin
			prdata = APB_DATA_W'(start_q);
		end else begin
			prdata = APB_DATA_W'(end_q);
		end
	end

	// bump pointer follows a write of the region start
	assign start_load   = wr_en && (reg_sel == REG_START);
	assign region_start = start_q;
	assign region_end   = end_q;

endmodule
`default_nettype wire

### rtl/slfa_bitmap.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slfa_bitmap
// Used-slot bitmap: one bit per slot, registered read, swept clear after reset.
// ----------------------------------------------------------------------------
module slfa_bitmap (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         rd_en,
	input  wire logic [slfa_pkg::SLOT_W-1:0]  rd_addr,
	input  wire slfa_pkg::bm_wr_t             wr,
	output logic                              rd_bit,
	output logic                              clearing
);
	import slfa_pkg::*;

	logic              mem [SLOT_COUNT];
	logic [SLOT_W-1:0] clr_idx_q;
	logic              clearing_q;
	logic              rd_bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			if (clr_idx_q == SLOT_W'(SLOT_COUNT - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_idx_q] <= 1'b0;
		end else if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_bit_q <= mem[rd_addr];
		end
	end

	assign rd_bit   = rd_bit_q;
	assign clearing = clearing_q;

endmodule
`default_nettype wire

### rtl/slfa_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slfa_fifo
// FIFO of released slots: memory, head/tail pointers and fill count.
// ----------------------------------------------------------------------------
module slfa_fifo (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         rd_en,
	input  wire slfa_pkg::fifo_ctl_t          ctl,
	output logic      [slfa_pkg::SLOT_W-1:0]  rd_data,
	output logic      [slfa_pkg::FILL_W-1:0]  fill
);
	import slfa_pkg::*;

	logic [SLOT_W-1:0] mem [SLOT_COUNT];
	logic [SLOT_W-1:0] head_q;
	logic [SLOT_W-1:0] tail_q;
	logic [FILL_W-1:0] fill_q;
	logic [SLOT_W-1:0] rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else begin
			if (ctl.pop) begin
				head_q <= ptr_inc(head_q);
			end
			if (ctl.push) begin
				tail_q <= ptr_inc(tail_q);
			end
			// pop and push never come from the same request
			if (ctl.pop) begin
				fill_q <= fill_q - 1'b1;
			end else if (ctl.push) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[tail_q] <= ctl.push_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[head_q];
		end
	end

	assign rd_data = rd_data_q;
	assign fill    = fill_q;

endmodule
`default_nettype wire

### rtl/slot_free_list_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slot_free_list_allocator
// Slot allocator over a configured region: FIFO of released slots first,
// bump pointer otherwise (also for runs), used bitmap checked on release.
//
//   channel   dir   payload (low bit first)                 handshake
//   s_*       in    action[1:0] run_length[12:2] slot_in    tvalid/tready
//   m_*       out   slot_out[9:0] status[12:10]             tvalid/tready
//   apb       in    region_start @0x0, region_end @0x4      psel/penable
//
// Each request is handled in two steps: the accept cycle reads the bitmap and
// the FIFO head, the decide step writes back and loads the result. The
// single-port read-modify-write of the bitmap and FIFO sets this split.
// After reset the bitmap is swept clear; s_tready is low then.
// A full result register holds the request in flight until m_tready.
// ----------------------------------------------------------------------------
module slot_free_list_allocator (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// action[1:0], run_length[12:2], slot_in[28:13], zero fill
	input  wire logic [slfa_pkg::IN_DATA_W-1:0]   s_tdata,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// slot_out[9:0], status[12:10], zero fill
	output logic      [slfa_pkg::OUT_DATA_W-1:0]  m_tdata,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [slfa_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [slfa_pkg::APB_DATA_W-1:0]  pwdata,
	output logic      [slfa_pkg::APB_DATA_W-1:0]  prdata,
	output logic                                  pready
);
	import slfa_pkg::*;

	logic [REG_W-1:0]     region_start;
	logic [REG_W-1:0]     region_end;
	logic                 start_load;

	logic [ACT_W-1:0]     in_action;
	logic [RUN_W-1:0]     in_run;
	logic [SLOT_IN_W-1:0] in_slot;
	logic                 accept;

	logic                 valid_s1;
	logic [ACT_W-1:0]     action_s1;
	logic [RUN_W-1:0]     run_s1;
	logic [SLOT_IN_W-1:0] slot_in_s1;
	logic                 done;

	logic [REG_W-1:0]     next_fresh_q;
	logic [REG_W-1:0]     next_fresh_d;

	logic                 bm_bit;
	logic                 clearing;
	bm_wr_t               bm_wr;
	fifo_ctl_t            fifo_ctl;
	logic [SLOT_W-1:0]    fifo_data;
	logic [FILL_W-1:0]    fifo_fill;

	logic [REG_W-1:0]     eff_end;
	logic [REG_W:0]       run_sum;
	logic                 rel_in_region;
	logic [REG_W-1:0]     slot_d;
	logic [STATUS_W-1:0]  status_d;

	logic                 out_valid_q;
	logic [SLOT_OUT_W-1:0] slot_out_q;
	logic [STATUS_W-1:0]  status_q;

	slfa_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.region_start (region_start),
		.region_end   (region_end),
		.start_load   (start_load)
	);

	assign in_action = s_tdata[ACT_W-1:0];
	assign in_run    = s_tdata[ACT_W+RUN_W-1:ACT_W];
	assign in_slot   = s_tdata[ACT_W+RUN_W+SLOT_IN_W-1:ACT_W+RUN_W];

	assign s_tready = !valid_s1 && !clearing;
	assign accept   = s_tvalid && s_tready;
	assign done     = valid_s1 && (!out_valid_q || m_tready);

	slfa_bitmap u_bitmap (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (in_slot[SLOT_W-1:0]),
		.wr       (bm_wr),
		.rd_bit   (bm_bit),
		.clearing (clearing)
	);

	slfa_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.ctl     (fifo_ctl),
		.rd_data (fifo_data),
		.fill    (fifo_fill)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1  <= in_action;
			run_s1     <= in_run;
			slot_in_s1 <= in_slot;
		end
	end

	// decide the request in flight
	always_comb begin
		eff_end = (region_end > REG_W'(SLOT_COUNT)) ? REG_W'(SLOT_COUNT) : region_end;
		run_sum = {1'b0, next_fresh_q} + {1'b0, run_s1};
		rel_in_region = (slot_in_s1 >= SLOT_IN_W'(region_start))
			&& (slot_in_s1 < SLOT_IN_W'(eff_end));

		slot_d       = '0;
		status_d     = ST_OK;
		next_fresh_d = next_fresh_q;
		bm_wr        = '0;
		fifo_ctl     = '0;

		case (action_s1)
			ACT_ALLOC: begin
				if (fifo_fill != '0) begin
					slot_d       = REG_W'(fifo_data);
					fifo_ctl.pop = done;
				end else if (next_fresh_q < eff_end) begin
					slot_d       = next_fresh_q;
					next_fresh_d = next_fresh_q + 1'b1;
				end else begin
					status_d = ST_EXHAUSTED;
				end
				// a reused slot from an older region is handed out but not marked
				if (status_d == ST_OK && slot_d >= region_start && slot_d < eff_end) begin
					bm_wr.en   = done;
					bm_wr.addr = slot_d[SLOT_W-1:0];
					bm_wr.data = 1'b1;
				end
			end
			ACT_RUN: begin
				if (run_sum > {1'b0, eff_end}) begin
					status_d = ST_RUN;
				end else begin
					slot_d       = next_fresh_q;
					next_fresh_d = run_sum[REG_W-1:0];
				end
			end
			ACT_RELEASE: begin
				if (!rel_in_region) begin
					status_d = ST_RANGE;
				end else if (!bm_bit) begin
					status_d = ST_UNUSED;
				end else begin
					bm_wr.en   = done;
					bm_wr.addr = slot_in_s1[SLOT_W-1:0];
					bm_wr.data = 1'b0;
					if (fifo_fill < FILL_W'(SLOT_COUNT)) begin
						fifo_ctl.push      = done;
						fifo_ctl.push_data = slot_in_s1[SLOT_W-1:0];
					end
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_fresh_q <= '0;
		end else if (start_load) begin
			next_fresh_q <= pwdata[REG_W-1:0];
		end else if (done) begin
			next_fresh_q <= next_fresh_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			slot_out_q <= slot_d[SLOT_OUT_W-1:0];
			status_q   <= status_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_W'({status_q, slot_out_q});

	// no request is taken while the bitmap is being swept
	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !s_tready)
		else $error("request accepted during bitmap clear");

	// a finished request always shows up as a result next cycle
	a_done_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> m_tvalid)
		else $error("finished request produced no result");

	// fill count stays within the FIFO depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_fill <= FILL_W'(SLOT_COUNT))
		else $error("free list fill count beyond depth");

	// bitmap and FIFO are never written while a request is being accepted
	a_no_write_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (!bm_wr.en && !fifo_ctl.push && !fifo_ctl.pop))
		else $error("memory write collides with request read");

endmodule
`default_nettype wire
